>>> design/bmpu_pkg.sv
// Shared types, constants and helper functions of the BMP scan-line pixel unpacker.
package bmpu_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_W   = 13;
  localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int POS_W   = $clog2(MAX_WIDTH * 3 + 4);
  localparam int X_W     = 12;
  localparam int Y_W     = 12;
  localparam int CNT_W   = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  // Commands.
  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_PIXEL   = 1'b1;

  // Register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEPTH  = 2'd2;

  // Depth codes.
  localparam logic [1:0] DEPTH_1  = 2'd0;
  localparam logic [1:0] DEPTH_4  = 2'd1;
  localparam logic [1:0] DEPTH_8  = 2'd2;
  localparam logic [1:0] DEPTH_24 = 2'd3;

  typedef struct packed {
    logic                 is_pal;
    logic [7:0]           idx;
    logic [23:0]          rgb;
    logic [1:0]           depth;
    logic [7:0]           data;
    logic                 gray;
    logic [X_W-1:0]       col;
    logic [Y_W-1:0]       row;
    logic [CNT_W-1:0]     count;
    logic                 done;
  } bmpu_job_t;

  function automatic logic [WIDTH_W-1:0] clamp_width(logic [CFG_W-1:0] v);
    logic [WIDTH_W-1:0] r;
    if (v == '0) begin
      r = WIDTH_W'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = WIDTH_W'(MAX_WIDTH);
    end else begin
      r = WIDTH_W'(v);
    end
    return r;
  endfunction

  // Top row of the image: the clamped height less one.
  function automatic logic [ROW_W-1:0] top_row(logic [CFG_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_HEIGHT) begin
      r = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      r = ROW_W'(v - CFG_W'(1));
    end
    return r;
  endfunction

endpackage

>>> design/bmpu_if.sv
// Valid/ready channel interfaces for the input items and the emitted pixels.
interface bmpu_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] palette_index;
  logic [7:0] palette_red;
  logic [7:0] palette_green;
  logic [7:0] palette_blue;
  logic [7:0] data_byte;

  modport source (output valid, command, palette_index, palette_red, palette_green,
                  palette_blue, data_byte, input ready);
  modport sink (input valid, command, palette_index, palette_red, palette_green,
                palette_blue, data_byte, output ready);
endinterface

interface bmpu_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        gray_only;
  logic        last_of_run;
  logic        image_done;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, gray_only,
                  last_of_run, image_done, input ready);
  modport sink (input valid, pixel_x, pixel_y, red, green, blue, gray_only,
                last_of_run, image_done, output ready);
endinterface

>>> design/bmpu_front.sv
// Front end: configuration registers, scan-line counters and job building per input beat.
module bmpu_front import bmpu_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  bmpu_in_if.sink          in,
  output logic             push,
  output bmpu_job_t        job,
  input  logic             full
);

  logic [CFG_W-1:0]   image_width;
  logic [CFG_W-1:0]   image_height;
  logic [1:0]         depth_code;
  logic               colour_seen;
  logic [WIDTH_W-1:0] column_count;
  logic [ROW_W-1:0]   row_count;
  logic [POS_W-1:0]   row_byte_pos;
  logic [1:0]         phase;
  logic [7:0]         part_blue;
  logic [7:0]         part_green;

  logic [WIDTH_W-1:0] column_count_next;
  logic [ROW_W-1:0]   row_count_next;
  logic [POS_W-1:0]   row_byte_pos_next;
  logic [1:0]         phase_next;
  logic               colour_seen_next;

  logic               accept;
  logic [WIDTH_W-1:0] w;
  logic [POS_W-1:0]   w_wide;
  logic [POS_W-1:0]   datalen;
  logic [POS_W-1:0]   padded;
  logic [POS_W-1:0]   pos_inc;
  logic               wrap;
  logic               in_data;
  logic [WIDTH_W-1:0] remain;
  logic [CNT_W-1:0]   n;
  logic               gray;
  logic               done;
  logic               idx_ok;
  logic [CFG_W-1:0]   height_sel;

  assign in.ready = !full;
  assign accept   = in.valid && in.ready;

  assign w       = clamp_width(image_width);
  assign w_wide  = POS_W'(w);
  assign pos_inc = row_byte_pos + POS_W'(1);
  assign gray    = (depth_code != DEPTH_24) && !colour_seen;
  assign remain  = w - column_count;
  assign idx_ok  = 32'(in.palette_index) < PALETTE_DEPTH;

  always_comb begin
    case (depth_code)
      DEPTH_1:  datalen = (w_wide + POS_W'(7)) >> 3;
      DEPTH_4:  datalen = (w_wide + POS_W'(1)) >> 1;
      DEPTH_8:  datalen = w_wide;
      default:  datalen = w_wide + (w_wide << 1);
    endcase
  end

  assign padded  = (datalen + POS_W'(3)) & ~POS_W'(3);
  assign wrap    = pos_inc >= padded;
  assign in_data = row_byte_pos < datalen;

  always_comb begin
    n = '0;
    if (in_data) begin
      case (depth_code)
        DEPTH_1:  n = (remain >= WIDTH_W'(8)) ? CNT_W'(8) : CNT_W'(remain);
        DEPTH_4:  n = (remain >= WIDTH_W'(2)) ? CNT_W'(2) : CNT_W'(1);
        DEPTH_8:  n = CNT_W'(1);
        default:  n = (phase == 2'd2) ? CNT_W'(1) : CNT_W'(0);
      endcase
    end
  end

  // The pixel that ends row 0 is always the last one of its beat.
  assign done = (row_count == '0) && ((column_count + WIDTH_W'(n)) == w);

  always_comb begin
    job        = '0;
    job.is_pal = (in.command == CMD_PALETTE);
    job.idx    = in.palette_index;
    job.depth  = depth_code;
    job.data   = in.data_byte;
    job.gray   = gray;
    job.col    = X_W'(column_count);
    job.row    = Y_W'(row_count);
    job.count  = n;
    job.done   = done;
    if (in.command == CMD_PALETTE) begin
      job.rgb = {in.palette_red, in.palette_green, in.palette_blue};
    end else begin
      job.rgb = {in.data_byte, part_green, part_blue};
    end
  end

  assign push = accept && ((in.command == CMD_PALETTE) || (n != '0));

  assign height_sel = (cfg_index == REG_HEIGHT) ? cfg_data : image_height;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    row_byte_pos_next = row_byte_pos;
    phase_next        = phase;
    colour_seen_next  = colour_seen;
    if (accept && in.command == CMD_PALETTE) begin
      if (idx_ok && (in.palette_red != in.palette_green ||
                     in.palette_green != in.palette_blue)) begin
        colour_seen_next = 1'b1;
      end
    end else if (accept) begin
      if (wrap) begin
        row_byte_pos_next = '0;
        column_count_next = '0;
        phase_next        = 2'd0;
        row_count_next    = (row_count == '0) ? top_row(image_height)
                                              : row_count - ROW_W'(1);
      end else begin
        row_byte_pos_next = pos_inc;
        column_count_next = column_count + WIDTH_W'(n);
        phase_next        = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
      depth_code   <= DEPTH_8;
      colour_seen  <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
      row_byte_pos <= '0;
      phase        <= 2'd0;
    end else if (cfg_write && (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_DEPTH})) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default:    depth_code   <= cfg_data[1:0];
      endcase
      column_count <= '0;
      row_byte_pos <= '0;
      phase        <= 2'd0;
      row_count    <= top_row(height_sel);
    end else begin
      colour_seen  <= colour_seen_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      row_byte_pos <= row_byte_pos_next;
      phase        <= phase_next;
    end
  end

  // Blue and green of a 24-bit pixel wait here until its red byte arrives.
  always_ff @(posedge clk) begin
    if (accept && in.command == CMD_PIXEL && in_data && depth_code == DEPTH_24) begin
      if (phase == 2'd0) begin
        part_blue <= in.data_byte;
      end else if (phase == 2'd1) begin
        part_green <= in.data_byte;
      end
    end
  end

endmodule

>>> design/bmpu_queue.sv
// Short job queue between the front end and the pixel back end.
module bmpu_queue import bmpu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bmpu_job_t push_job,
  output logic      full,
  input  logic      pop,
  output bmpu_job_t head,
  output logic      empty
);

  bmpu_job_t       slots [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == (QP_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QP_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QP_W+1)'(1);
        2'b01:   count <= count - (QP_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

>>> design/bmpu_back.sv
// Back end: palette memory, pixel expansion one per cycle while the output is not held, and the output register.
module bmpu_back import bmpu_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  bmpu_job_t head,
  input  logic      empty,
  output logic      pop,
  bmpu_out_if.source out
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [23:0]      palette [PALETTE_DEPTH];

  logic             active;
  bmpu_job_t        cur;
  logic [7:0]       sh;
  logic [X_W-1:0]   x;
  logic [CNT_W-1:0] remain;

  logic             out_valid;
  logic [X_W-1:0]   o_x;
  logic [Y_W-1:0]   o_y;
  logic [7:0]       o_r;
  logic [7:0]       o_g;
  logic [7:0]       o_b;
  logic             o_use_pal;
  logic             o_oob;
  logic             o_gray;
  logic             o_last;
  logic             o_done;
  logic [23:0]      rd_data;

  logic             advance;
  logic             issue;
  logic             last;
  logic             free;
  logic             load;
  logic [7:0]       pix_idx;
  logic             use_pal;
  logic [7:0]       dr;
  logic [7:0]       dg;
  logic [7:0]       db;
  logic             oob;
  logic             head_ok;

  assign advance = !out_valid || out.ready;
  assign issue   = active && advance;
  assign last    = (remain == CNT_W'(1));
  assign free    = !active || (issue && last);
  assign pop     = free && !empty;
  assign load    = pop && !head.is_pal;
  assign head_ok = 32'(head.idx) < PALETTE_DEPTH;

  always_comb begin
    pix_idx = sh;
    use_pal = 1'b0;
    dr      = '0;
    dg      = '0;
    db      = '0;
    case (cur.depth)
      DEPTH_1: begin
        dr = {8{sh[7]}};
        dg = cur.gray ? 8'h00 : {8{sh[7]}};
        db = cur.gray ? 8'h00 : {8{sh[7]}};
      end
      DEPTH_4: begin
        pix_idx = {4'h0, sh[7:4]};
        use_pal = !cur.gray;
        dr      = {4'h0, sh[7:4]};
      end
      DEPTH_8: begin
        use_pal = !cur.gray;
        dr      = sh;
      end
      default: begin
        dr = cur.rgb[23:16];
        dg = cur.rgb[15:8];
        db = cur.rgb[7:0];
      end
    endcase
  end

  assign oob = 32'(pix_idx) >= PALETTE_DEPTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (free) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur    <= head;
      sh     <= head.data;
      x      <= head.col;
      remain <= head.count;
    end else if (issue) begin
      x      <= x + X_W'(1);
      remain <= remain - CNT_W'(1);
      case (cur.depth)
        DEPTH_1: sh <= sh << 1;
        DEPTH_4: sh <= sh << 4;
        default: sh <= sh;
      endcase
    end
  end

  // A palette write in the same cycle as a read returns the old entry to the
  // earlier pixel, which keeps the order of the input beats.
  always_ff @(posedge clk) begin
    if (pop && head.is_pal && head_ok) begin
      palette[head.idx[AW-1:0]] <= head.rgb;
    end
    if (issue) begin
      rd_data <= palette[pix_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      o_x       <= x;
      o_y       <= cur.row;
      o_r       <= dr;
      o_g       <= dg;
      o_b       <= db;
      o_use_pal <= use_pal;
      o_oob     <= oob;
      o_gray    <= cur.gray;
      o_last    <= last;
      o_done    <= last && cur.done;
    end
  end

  assign out.valid       = out_valid;
  assign out.pixel_x     = o_x;
  assign out.pixel_y     = o_y;
  assign out.red         = !o_use_pal ? o_r : (o_oob ? 8'h00 : rd_data[23:16]);
  assign out.green       = !o_use_pal ? o_g : (o_oob ? 8'h00 : rd_data[15:8]);
  assign out.blue        = !o_use_pal ? o_b : (o_oob ? 8'h00 : rd_data[7:0]);
  assign out.gray_only   = o_gray;
  assign out.last_of_run = o_last;
  assign out.image_done  = o_done;

endmodule

>>> design/bmp_scanline_pixel_unpacker_unit.sv
// Top level of the BMP scan-line pixel unpacker.
// Takes palette writes and raw bytes of uncompressed bottom-up BMP pixel data at 1, 4,
// 8 or 24 bits per pixel and emits one pixel per beat with its column, row, colour and
// flags; row padding bytes give no pixels. The front end accepts one input beat per
// cycle while its four-entry job queue has room, and a byte that yields no pixel is
// never pushed into that queue. While its output is not held back, the back end emits
// one pixel per cycle and writes one palette entry per cycle, so a data byte keeps it
// busy until every pixel it yields (up to eight at 1 bit per pixel) is issued; this
// pixel rate sets the sustained throughput. A pixel passes through the queue slot, the
// back end's job register and the output register. Configuration writes restart the
// image at the top row and must be made while the block is idle.
module bmp_scanline_pixel_unpacker_unit import bmpu_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  bmpu_in_if.sink          in,
  bmpu_out_if.source       out
);

  logic      push;
  bmpu_job_t push_job;
  logic      full;
  logic      pop;
  bmpu_job_t head;
  logic      empty;

  bmpu_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in        (in),
    .push      (push),
    .job       (push_job),
    .full      (full)
  );

  bmpu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  bmpu_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .out   (out)
  );

endmodule

>>> tb/tb_bmp_scanline_pixel_unpacker_unit.sv
// Testbench for the BMP scan-line pixel unpacker: directed and random beats checked against a predictor.
`timescale 1ns / 1ps

module tb_bmp_scanline_pixel_unpacker_unit;
  import bmpu_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_ITEMS  = 100;
  localparam int MAX_REPORTS   = 50;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic       command;
    logic [7:0] pal_idx;
    logic [7:0] pal_r;
    logic [7:0] pal_g;
    logic [7:0] pal_b;
    logic [7:0] data;
  } bmp_item_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        gray_only;
    logic        last_of_run;
    logic        image_done;
  } pixel_t;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bmpu_in_if  in_ch ();
  bmpu_out_if out_ch ();

  bmp_scanline_pixel_unpacker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in        (in_ch),
    .out       (out_ch)
  );

  // Stimulus side.
  bmp_item_t   pending_items[$];
  int          item_count;
  int          in_idle_pct;
  int          out_idle_pct;
  logic        hold_arm;
  bit          gen_written[256];
  logic [7:0]  written_all[$];
  logic [7:0]  written_low[$];
  logic        gen_colour;
  logic [1:0]  gen_depth;

  // Handshake state.
  int   send_gap;
  int   recv_gap;
  int   hold_left;
  logic hold_done;

  // Predictor state.
  logic [23:0] pal_mem[256];
  logic        colour_flag;
  logic [12:0] img_w_reg;
  logic [12:0] img_h_reg;
  logic [1:0]  depth_reg;
  int          col_cnt;
  int          row_cnt;
  int          byte_pos;
  logic [15:0] partial;
  pixel_t      byte_pixels[$];
  pixel_t      expected_pixels[$];

  int errors;
  int pixel_beats;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic report(input string msg);
    if (errors < MAX_REPORTS) begin
      $display("%0t ns: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic int clamp_to(input logic [12:0] v, input int hi);
    int r;
    r = v;
    if (r < 1) r = 1;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic int row_bytes(input int w, input logic [1:0] d);
    case (d)
      DEPTH_1: return (w + 7) / 8;
      DEPTH_4: return (w + 1) / 2;
      DEPTH_8: return w;
      default: return 3 * w;
    endcase
  endfunction

  function automatic int idle_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // ---------------------------------------------------------------- predictor

  task automatic restart_image();
    col_cnt  = 0;
    byte_pos = 0;
    partial  = '0;
    row_cnt  = clamp_to(img_h_reg, MAX_HEIGHT) - 1;
  endtask

  task automatic reset_model();
    colour_flag = 1'b0;
    img_w_reg   = 13'd1;
    img_h_reg   = 13'd1;
    depth_reg   = DEPTH_8;
    restart_image();
  endtask

  task automatic write_model_reg(input logic [1:0] idx, input logic [12:0] val);
    case (idx)
      REG_WIDTH: begin
        img_w_reg = val;
        restart_image();
      end
      REG_HEIGHT: begin
        img_h_reg = val;
        restart_image();
      end
      REG_DEPTH: begin
        depth_reg = val[1:0];
        restart_image();
      end
      default: ;
    endcase
  endtask

  task automatic load_palette_entry(input logic [7:0] idx, input logic [7:0] r, g, b);
    pal_mem[idx] = {r, g, b};
    if (r != g || g != b) colour_flag = 1'b1;
  endtask

  task automatic emit_pixel(input int w, input logic [7:0] r, g, b, input logic gray);
    pixel_t p;
    p.x           = 12'(col_cnt);
    p.y           = 12'(row_cnt);
    p.red         = r;
    p.green       = gray ? 8'h00 : g;
    p.blue        = gray ? 8'h00 : b;
    p.gray_only   = gray;
    p.last_of_run = 1'b0;
    p.image_done  = (row_cnt == 0 && col_cnt + 1 == w);
    byte_pixels.push_back(p);
    col_cnt++;
  endtask

  task automatic index_pixel(input int w, input logic [7:0] idx, input logic gray);
    if (gray) begin
      emit_pixel(w, idx, 8'h00, 8'h00, 1'b1);
    end else begin
      emit_pixel(w, pal_mem[idx][23:16], pal_mem[idx][15:8], pal_mem[idx][7:0], 1'b0);
    end
  endtask

  task automatic unpack_data_byte(input logic [7:0] b);
    int         w;
    int         row_len;
    int         padded;
    logic       gray;
    logic [7:0] v;
    pixel_t     p;
    w       = clamp_to(img_w_reg, MAX_WIDTH);
    row_len = row_bytes(w, depth_reg);
    padded  = (row_len + 3) / 4 * 4;
    gray    = (depth_reg != DEPTH_24) && !colour_flag;
    byte_pixels.delete();
    if (byte_pos < row_len) begin
      case (depth_reg)
        DEPTH_1: begin
          for (int k = 0; k < 8 && col_cnt < w; k++) begin
            v = b[7-k] ? 8'hff : 8'h00;
            emit_pixel(w, v, v, v, gray);
          end
        end
        DEPTH_4: begin
          index_pixel(w, {4'h0, b[7:4]}, gray);
          if (col_cnt < w) index_pixel(w, {4'h0, b[3:0]}, gray);
        end
        DEPTH_8: index_pixel(w, b, gray);
        default: begin
          // True-colour bytes arrive blue first, then green, then red.
          case (byte_pos % 3)
            0: partial = {8'h00, b};
            1: partial[15:8] = b;
            default: begin
              emit_pixel(w, b, partial[15:8], partial[7:0], 1'b0);
              partial = '0;
            end
          endcase
        end
      endcase
    end
    byte_pos++;
    if (byte_pos >= padded) begin
      byte_pos = 0;
      col_cnt  = 0;
      partial  = '0;
      row_cnt  = (row_cnt == 0) ? clamp_to(img_h_reg, MAX_HEIGHT) - 1 : row_cnt - 1;
    end
    if (byte_pixels.size() != 0) begin
      p = byte_pixels.pop_back();
      p.last_of_run = 1'b1;
      byte_pixels.push_back(p);
    end
    foreach (byte_pixels[i]) expected_pixels.push_back(byte_pixels[i]);
  endtask

  always @(posedge clk) begin : predict
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_write) write_model_reg(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.command == CMD_PALETTE) begin
          load_palette_entry(in_ch.palette_index, in_ch.palette_red, in_ch.palette_green,
                             in_ch.palette_blue);
        end else begin
          unpack_data_byte(in_ch.data_byte);
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver and monitor

  always @(posedge clk) begin : driver
    bmp_item_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_ch.command       <= it.command;
        in_ch.palette_index <= it.pal_idx;
        in_ch.palette_red   <= it.pal_r;
        in_ch.palette_green <= it.pal_g;
        in_ch.palette_blue  <= it.pal_b;
        in_ch.data_byte     <= it.data;
        in_ch.valid         <= 1'b1;
        send_gap = idle_gap(in_idle_pct);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      recv_gap  = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      // One long hold-off so that the job queue fills and the input stalls.
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      recv_gap = idle_gap(out_idle_pct);
      out_ch.ready <= (recv_gap == 0);
    end
  end

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("beat %0d %s: got %0d, expected %0d", pixel_beats, name, got, want));
    end
  endtask

  always @(posedge clk) begin : monitor
    pixel_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        report($sformatf("beat %0d at (%0d,%0d) arrived with no pixel expected",
                         pixel_beats, out_ch.pixel_x, out_ch.pixel_y));
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_x", out_ch.pixel_x, want.x);
        check_field("pixel_y", out_ch.pixel_y, want.y);
        check_field("red", out_ch.red, want.red);
        check_field("green", out_ch.green, want.green);
        check_field("blue", out_ch.blue, want.blue);
        check_field("gray_only", out_ch.gray_only, want.gray_only);
        check_field("last_of_run", out_ch.last_of_run, want.last_of_run);
        check_field("image_done", out_ch.image_done, want.image_done);
      end
      pixel_beats++;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_palette(input logic [7:0] idx, input logic [7:0] r, g, b);
    bmp_item_t it;
    it.command = CMD_PALETTE;
    it.pal_idx = idx;
    it.pal_r   = r;
    it.pal_g   = g;
    it.pal_b   = b;
    it.data    = 8'($urandom);
    pending_items.push_back(it);
    if (!gen_written[idx]) begin
      gen_written[idx] = 1'b1;
      written_all.push_back(idx);
      if (idx < 16) written_low.push_back(idx);
    end
    if (r != g || g != b) gen_colour = 1'b1;
    item_count++;
  endtask

  task automatic push_data(input logic [7:0] b);
    bmp_item_t it;
    it.command = CMD_PIXEL;
    it.pal_idx = 8'($urandom);
    it.pal_r   = 8'($urandom);
    it.pal_g   = 8'($urandom);
    it.pal_b   = 8'($urandom);
    it.data    = b;
    pending_items.push_back(it);
    item_count++;
  endtask

  // Once colour is on, palette lookups must only hit entries that have been loaded.
  function automatic logic [7:0] loaded_byte(input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] pick;
    r = b;
    if (gen_colour && gen_depth == DEPTH_8 && !gen_written[r]) begin
      r = written_all[$urandom_range(written_all.size() - 1)];
    end
    if (gen_colour && gen_depth == DEPTH_4) begin
      if (!gen_written[{4'h0, r[7:4]}]) begin
        pick = written_low[$urandom_range(written_low.size() - 1)];
        r[7:4] = pick[3:0];
      end
      if (!gen_written[{4'h0, r[3:0]}]) begin
        pick = written_low[$urandom_range(written_low.size() - 1)];
        r[3:0] = pick[3:0];
      end
    end
    return r;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_pixels.size() != 0);
    // A trailing palette beat or padding byte gives no pixel, so let the pipeline drain.
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_DEPTH) gen_depth = val[1:0];
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [12:0] w, h, d);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_DEPTH, d);
  endtask

  task automatic random_image_phase();
    logic [12:0] wv;
    logic [12:0] hv;
    logic [1:0]  d;
    int          full;
    int          n;
    logic [7:0]  v;
    wait_idle();
    case ($urandom_range(2))
      0: in_idle_pct = 0;
      1: in_idle_pct = 15;
      default: in_idle_pct = 40;
    endcase
    case ($urandom_range(2))
      0: out_idle_pct = 0;
      1: out_idle_pct = 15;
      default: out_idle_pct = 40;
    endcase
    d = 2'($urandom_range(3));
    if ($urandom_range(9) == 0) begin
      // Extreme geometry: one to twelve bytes are sent, a part of the first scan line unless the width is zero.
      case ($urandom_range(3))
        0: wv = 13'd0;
        1: wv = 13'd4096;
        2: wv = 13'd8191;
        default: wv = 13'($urandom_range(8191, 4097));
      endcase
      hv = 13'($urandom_range(8191));
      n  = $urandom_range(12, 1);
    end else begin
      wv   = 13'((d == DEPTH_24) ? $urandom_range(6, 1) : $urandom_range(24, 1));
      hv   = 13'($urandom_range(3));
      full = (row_bytes(wv, d) + 3) / 4 * 4 * clamp_to(hv, MAX_HEIGHT);
      if ($urandom_range(3) != 0) n = full + $urandom_range(3);
      else n = $urandom_range(full, 1);
    end
    if ($urandom_range(9) != 0) write_reg(REG_WIDTH, wv);
    if ($urandom_range(9) != 0) write_reg(REG_HEIGHT, hv);
    if ($urandom_range(9) != 0) write_reg(REG_DEPTH, {11'($urandom), d});
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        v = 8'($urandom);
        if (gen_colour) push_palette(8'($urandom), v, 8'($urandom), 8'($urandom));
        else push_palette(8'($urandom), v, v, v);
      end
      push_data(loaded_byte(8'($urandom)));
    end
  endtask

  initial begin : stimulus
    int         rand_start;
    logic [7:0] v;
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_index            = REG_WIDTH;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_PALETTE;
    in_ch.palette_index  = '0;
    in_ch.palette_red    = '0;
    in_ch.palette_green  = '0;
    in_ch.palette_blue   = '0;
    in_ch.data_byte      = '0;
    out_ch.ready         = 1'b0;
    in_idle_pct          = 0;
    out_idle_pct         = 0;
    hold_arm             = 1'b0;
    gen_colour           = 1'b0;
    gen_depth            = DEPTH_8;
    item_count           = 0;
    errors               = 0;
    pixel_beats          = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Gray image at the reset geometry: one 8-bit pixel, three padding bytes, then one pixel of a new image.
    push_palette(8'd0, 8'h00, 8'h00, 8'h00);
    push_palette(8'd255, 8'hff, 8'hff, 8'hff);
    push_palette(8'd15, 8'h0f, 8'h0f, 8'h0f);
    push_data(8'h00);
    push_data(8'hff);
    push_data(8'ha5);
    push_data(8'h5a);
    push_data(8'hff);

    // Two rows of three 1-bit pixels, then at 4 bits a row with a dropped nibble and two pixels of the next row.
    set_geometry(13'd3, 13'd2, {11'd0, DEPTH_1});
    push_data(8'ha0);
    push_data(8'h11);
    push_data(8'h22);
    push_data(8'h33);
    push_data(8'h5f);
    in_idle_pct  = 30;
    out_idle_pct = 30;
    set_geometry(13'd3, 13'd2, {11'd0, DEPTH_4});
    push_data(8'hf0);
    push_data(8'h1e);
    push_data(8'h00);
    push_data(8'h00);
    push_data(8'h7c);

    // True colour, and a write to the unused register index, which changes nothing.
    set_geometry(13'd0, 13'd0, {11'd0, DEPTH_24});
    push_data(8'h01);
    push_data(8'h02);
    wait_idle();
    write_reg(REG_UNUSED, 13'h1fff);
    push_data(8'h03);
    push_data(8'hee);

    // The first palette entry with unequal components turns colour on for good.
    wait_idle();
    push_palette(8'd128, 8'h10, 8'h20, 8'h30);
    set_geometry(13'd2, 13'd1, {11'd0, DEPTH_8});
    push_data(8'd128);
    push_data(8'hff);
    set_geometry(13'd3, 13'd1, {11'd0, DEPTH_4});
    push_data(8'h0f);
    push_data(8'hf0);
    set_geometry(13'd8191, 13'd8191, {11'h7ff, DEPTH_1});
    push_data(8'h81);
    push_data(8'h7e);
    set_geometry(13'd4096, 13'd4096, {11'd0, DEPTH_8});
    push_data(8'hff);

    // Random part. The long receiver hold-off comes first, while the sender keeps offering.
    rand_start = item_count;
    set_geometry(13'd16, 13'd4, {11'd0, DEPTH_1});
    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (int i = 0; i < 16; i++) push_data(loaded_byte(8'($urandom)));
    hold_arm = 1'b1;
    while (item_count - rand_start < RANDOM_ITEMS / 2) random_image_phase();
    wait_idle();
    v = 8'($urandom);
    push_palette(8'($urandom), v, v ^ 8'h80, 8'($urandom));
    while (item_count - rand_start < RANDOM_ITEMS) random_image_phase();

    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/bmpu_pkg.sv
design/bmpu_if.sv
design/bmpu_front.sv
design/bmpu_queue.sv
design/bmpu_back.sv
design/bmp_scanline_pixel_unpacker_unit.sv
tb/tb_bmp_scanline_pixel_unpacker_unit.sv
